>>> rtl/sbfoc_pkg.sv
package sbfoc_pkg;

    // Ring geometry
    localparam int DEPTH    = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MAX_HITS = 32;
    localparam int HIT_W    = $clog2(MAX_HITS + 1);

    // Field widths
    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int LEN_W   = 32;
    localparam int LIMIT_W = 32;
    localparam int HDR_W   = 12;
    localparam int EVC_W   = 6;
    localparam int BYTES_W = 33;
    localparam int RET_W   = SIZE_W + HIT_W;
    localparam int IN_W    = 160;
    localparam int OUT_W   = 296;

    // Operation codes (input tuser)
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Result kinds (output tuser)
    localparam logic [1:0] KIND_PUT  = 2'd0;
    localparam logic [1:0] KIND_HIT  = 2'd1;
    localparam logic [1:0] KIND_MISS = 2'd2;

    // Register indexes
    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_HEADER = 1'b1;

    localparam logic [31:0] BUDGET_RESET = 32'd1048576;

    // One ring entry as held in memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [LEN_W-1:0]  len;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Ring slot of the entry step places after base
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] step);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(step);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/size_budget_fifo_offset_cache.sv
// Put: reads the oldest entry, evicts it and rereads the head while needed, then appends
//   and fills the result register. Get: per hit a scan of up to N held entries, one a cycle;
//   the closing lookup scans up to N more, then the final result follows. A full output register stalls.
// One request at a time; the ring memory, read one entry a cycle, sets the pace.
// A new request is taken while the last result still waits in the output register.
// Reset (rst_n low, asynchronous) empties the ring, budget 1048576, header 0.
module size_budget_fifo_offset_cache
    import sbfoc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data,
    // requests
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // offset[63:0], disk_size[95:64], fragment_len[127:96], read_limit[159:128]
    input  logic [IN_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic             s_axis_tuser,
    // results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // entry_offset[63:0], entry_length[95:64], evicted_count[101:96],
    // next_offset[165:102], oldest_offset[229:166], newest_offset[293:230], zero[295:294]
    output logic [OUT_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] P_CHECK = 3'd1;
    localparam logic [2:0] P_EVICT = 3'd2;
    localparam logic [2:0] P_WRITE = 3'd3;
    localparam logic [2:0] G_START = 3'd4;
    localparam logic [2:0] G_SCAN  = 3'd5;
    localparam logic [2:0] G_HIT   = 3'd6;
    localparam logic [2:0] G_FIN   = 3'd7;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [31:0]        budget_reg, budget_next;
    logic [HDR_W-1:0]   header_reg, header_next;
    logic [EVC_W-1:0]   evicted_reg, evicted_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [HIT_W-1:0]   hits_reg, hits_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [KEY_W-1:0]   oldest_reg, oldest_next;
    logic [KEY_W-1:0]   newest_reg, newest_next;
    logic [KEY_W-1:0]   offset_reg, offset_next;
    logic [SIZE_W-1:0]  dsize_reg, dsize_next;
    logic [LEN_W-1:0]   flen_reg, flen_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [KEY_W-1:0]   cur_reg, cur_next;
    logic [RET_W-1:0]   ret_reg, ret_next;
    logic [KEY_W-1:0]   pend_off_reg, pend_off_next;
    logic [LEN_W-1:0]   pend_len_reg, pend_len_next;
    logic [KEY_W-1:0]   pend_nxt_reg, pend_nxt_next;

    logic [1:0]         out_kind_reg, out_kind_next;
    logic [KEY_W-1:0]   out_eoff_reg, out_eoff_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic [EVC_W-1:0]   out_evc_reg, out_evc_next;
    logic [KEY_W-1:0]   out_nxt_reg, out_nxt_next;
    logic [KEY_W-1:0]   out_old_reg, out_old_next;
    logic [KEY_W-1:0]   out_new_reg, out_new_next;
    logic               out_last_reg, out_last_next;

    // ring memory
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_entry;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t             rd_entry;

    logic               in_accept;
    logic               out_free;
    logic               evict_cond;
    logic [KEY_W-1:0]   hit_next_off;
    logic [KEY_W-1:0]   cur_oldest;
    logic [KEY_W-1:0]   cur_newest;

    sbfoc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry      = entry_t'(rd_data);
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Evict while the ring is full or the new size breaks the budget
    assign evict_cond = (count_reg != '0) &&
                        ((count_reg >= CNT_W'(DEPTH)) ||
                         ((34'(bytes_reg) + 34'(dsize_reg)) > 34'(budget_reg)));

    assign hit_next_off = cur_reg + KEY_W'(rd_entry.len) + KEY_W'(header_reg);
    assign cur_oldest   = (count_reg != '0) ? oldest_reg : '0;
    assign cur_newest   = (count_reg != '0) ? newest_reg : '0;

    // Sequencer: next-state and datapath
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        budget_next     = budget_reg;
        header_next     = header_reg;
        evicted_next    = evicted_reg;
        scan_next       = scan_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        offset_next     = offset_reg;
        dsize_next      = dsize_reg;
        flen_next       = flen_reg;
        limit_next      = limit_reg;
        cur_next        = cur_reg;
        ret_next        = ret_reg;
        pend_off_next   = pend_off_reg;
        pend_len_next   = pend_len_reg;
        pend_nxt_next   = pend_nxt_reg;
        out_kind_next   = out_kind_reg;
        out_eoff_next   = out_eoff_reg;
        out_len_next    = out_len_reg;
        out_evc_next    = out_evc_reg;
        out_nxt_next    = out_nxt_reg;
        out_old_next    = out_old_reg;
        out_new_next    = out_new_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_of(head_reg, count_reg);
        wr_entry        = '{key: offset_reg, size: dsize_reg, len: flen_reg};
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        // take configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BUDGET: budget_next = cfg_data;
                CFG_HEADER: header_next = cfg_data[HDR_W-1:0];
                default:    budget_next = budget_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    offset_next     = s_axis_tdata[63:0];
                    dsize_next      = s_axis_tdata[95:64];
                    flen_next       = s_axis_tdata[127:96];
                    limit_next      = s_axis_tdata[159:128];
                    cur_next        = s_axis_tdata[63:0];
                    evicted_next    = '0;
                    ret_next        = '0;
                    hits_next       = '0;
                    pend_valid_next = 1'b0;
                    state_next      = (s_axis_tuser == OP_PUT) ? P_CHECK : G_START;
                end
            end

            // read the oldest entry; evict it or go on to append
            P_CHECK:
            begin
                rd_en      = 1'b1;
                state_next = evict_cond ? P_EVICT : P_WRITE;
            end

            P_EVICT:
            begin
                bytes_next   = bytes_reg - BYTES_W'(rd_entry.size);
                head_next    = slot_of(head_reg, CNT_W'(1));
                count_next   = count_reg - CNT_W'(1);
                evicted_next = (evicted_reg == '1) ? evicted_reg : evicted_reg + EVC_W'(1);
                state_next   = P_CHECK;
            end

            // append and report; the oldest key came from the last head read
            P_WRITE:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    bytes_next     = bytes_reg + BYTES_W'(dsize_reg);
                    newest_next    = offset_reg;
                    oldest_next    = (count_reg == '0) ? offset_reg : rd_entry.key;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PUT;
                    out_eoff_next  = '0;
                    out_len_next   = '0;
                    out_evc_next   = evicted_reg;
                    out_nxt_next   = '0;
                    out_old_next   = oldest_next;
                    out_new_next   = offset_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // start one lookup from the oldest entry
            G_START:
            begin
                if ((count_reg == '0) || (hits_reg == HIT_W'(MAX_HITS)) ||
                    (ret_reg >= RET_W'(limit_reg)))
                begin
                    state_next = G_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    scan_next  = '0;
                    state_next = G_SCAN;
                end
            end

            // compare one entry a cycle, oldest first
            G_SCAN:
            begin
                if (rd_entry.key == cur_reg)
                begin
                    state_next = G_HIT;
                end
                else if ((CNT_W'(scan_reg) + CNT_W'(1)) < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_of(head_reg, CNT_W'(scan_reg) + CNT_W'(1));
                    scan_next  = scan_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = G_FIN;
                end
            end

            // release the earlier hit, hold this one until the run's end is known
            G_HIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_HIT;
                        out_eoff_next  = pend_off_reg;
                        out_len_next   = pend_len_reg;
                        out_evc_next   = '0;
                        out_nxt_next   = pend_nxt_reg;
                        out_old_next   = cur_oldest;
                        out_new_next   = cur_newest;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_off_next   = cur_reg;
                    pend_len_next   = rd_entry.len;
                    pend_nxt_next   = hit_next_off;
                    ret_next        = ret_reg + RET_W'(rd_entry.size);
                    cur_next        = hit_next_off;
                    hits_next       = hits_reg + HIT_W'(1);
                    state_next      = G_START;
                end
            end

            // close the run: final hit, or a miss
            G_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_valid_reg ? KIND_HIT : KIND_MISS;
                    out_eoff_next   = pend_valid_reg ? pend_off_reg : '0;
                    out_len_next    = pend_valid_reg ? pend_len_reg : '0;
                    out_evc_next    = '0;
                    out_nxt_next    = pend_valid_reg ? pend_nxt_reg : '0;
                    out_old_next    = cur_oldest;
                    out_new_next    = cur_newest;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            budget_reg     <= BUDGET_RESET;
            header_reg     <= '0;
            evicted_reg    <= '0;
            scan_reg       <= '0;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            budget_reg     <= budget_next;
            header_reg     <= header_next;
            evicted_reg    <= evicted_next;
            scan_reg       <= scan_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        oldest_reg   <= oldest_next;
        newest_reg   <= newest_next;
        offset_reg   <= offset_next;
        dsize_reg    <= dsize_next;
        flen_reg     <= flen_next;
        limit_reg    <= limit_next;
        cur_reg      <= cur_next;
        ret_reg      <= ret_next;
        pend_off_reg <= pend_off_next;
        pend_len_reg <= pend_len_next;
        pend_nxt_reg <= pend_nxt_next;
        out_kind_reg <= out_kind_next;
        out_eoff_reg <= out_eoff_next;
        out_len_reg  <= out_len_next;
        out_evc_reg  <= out_evc_next;
        out_nxt_reg  <= out_nxt_next;
        out_old_reg  <= out_old_next;
        out_new_reg  <= out_new_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_new_reg, out_old_reg, out_nxt_reg,
                            out_evc_reg, out_len_reg, out_eoff_reg};

    // Ring fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("ring fill above depth");

    // An empty ring holds no bytes
    a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (bytes_reg == '0))
        else $error("bytes held with empty ring");

    // Memory is never read and written in the same cycle
    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("ring read and write overlap");

    // A get run never passes its hit limit
    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= HIT_W'(MAX_HITS))
        else $error("hit count above limit");

    // A scan only follows a start or itself
    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == G_SCAN) |-> ($past(state_reg) == G_START || $past(state_reg) == G_SCAN))
        else $error("scan entered out of sequence");

endmodule

>>> rtl/sbfoc_ram.sv
module sbfoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbfoc_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int KEY_HISTORY = 64;

    typedef struct {
        logic        op;
        logic [63:0] offset;
        logic [31:0] disk_size;
        logic [31:0] fragment_len;
        logic [31:0] read_limit;
    } cache_request_t;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] entry_offset;
        logic [31:0] entry_length;
        logic [5:0]  evicted;
        logic [63:0] next_offset;
        logic [63:0] oldest_offset;
        logic [63:0] newest_offset;
        logic        last;
    } cache_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_BUDGET;
    logic [31:0]      cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // offset, disk_size, fragment_len, read_limit
    logic [IN_W-1:0]  s_axis_tdata = '0;
    // operation
    logic             s_axis_tuser = OP_PUT;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // entry_offset, entry_length, evicted_count, next_offset, oldest_offset, newest_offset
    logic [OUT_W-1:0] m_axis_tdata;
    // kind
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;

    size_budget_fifo_offset_cache dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Cache shadow: ring contents, fill and the two registers
    logic [63:0]    key_mem [DEPTH];
    logic [31:0]    size_mem [DEPTH];
    logic [31:0]    length_mem [DEPTH];
    int             head_slot = 0;
    int             held_count = 0;
    logic [63:0]    held_bytes = '0;
    logic [31:0]    budget_reg = BUDGET_RESET;
    logic [11:0]    header_reg = '0;

    cache_request_t queued_requests [$];
    cache_result_t  results_due [$];
    logic [63:0]    recent_keys [$];
    cache_request_t current_request;

    int mismatches = 0;
    int results_seen = 0;
    int items_made = 0;
    int send_idle_pct = 30;
    int recv_stall_pct = 30;
    int hold_requests = 0;
    int holds_done = 0;
    int idle_cycles = 0;

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 20)
        begin
            $display("mismatch on result %0d, %s: got %h, expected %h",
                     results_seen, what, got, want);
        end
    endtask

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(1, 2);
        else if (pick < 95)
            return $urandom_range(3, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic cache_result_t stamp_result(input logic [1:0] kind);
        cache_result_t res;
        res = '{default: '0};
        res.kind = kind;
        if (held_count > 0)
        begin
            res.oldest_offset = key_mem[head_slot];
            res.newest_offset = key_mem[(head_slot + held_count - 1) % DEPTH];
        end
        return res;
    endfunction

    // Work out the results of one accepted request and update the shadow
    task automatic predict_cache_op(input cache_request_t req);
        cache_result_t res;
        int            evicted;
        int            hits;
        int            i;
        int            slot;
        bit            found;
        logic [63:0]   cursor;
        logic [63:0]   step_next;
        logic [63:0]   returned;
        if (req.op == OP_PUT)
        begin
            evicted = 0;
            while (held_count > 0 &&
                   (held_count >= DEPTH || held_bytes + req.disk_size > budget_reg))
            begin
                held_bytes = held_bytes - size_mem[head_slot];
                head_slot = (head_slot + 1) % DEPTH;
                held_count--;
                evicted++;
            end
            slot = (head_slot + held_count) % DEPTH;
            key_mem[slot] = req.offset;
            size_mem[slot] = req.disk_size;
            length_mem[slot] = req.fragment_len;
            held_count++;
            held_bytes = held_bytes + req.disk_size;
            res = stamp_result(KIND_PUT);
            res.evicted = (evicted > 63) ? 6'd63 : 6'(evicted);
            res.last = 1'b1;
            results_due.insert(results_due.size(), res);
        end
        else
        begin
            cursor = req.offset;
            returned = '0;
            hits = 0;
            slot = 0;
            while (hits < MAX_HITS)
            begin
                found = 1'b0;
                for (i = 0; i < held_count && !found; i++)
                begin
                    slot = (head_slot + i) % DEPTH;
                    found = (key_mem[slot] == cursor);
                end
                if (!found || returned >= req.read_limit)
                begin
                    break;
                end
                // Hold each hit back until it is known whether another follows
                if (hits > 0)
                begin
                    results_due.insert(results_due.size(), res);
                end
                step_next = cursor + length_mem[slot] + header_reg;
                res = stamp_result(KIND_HIT);
                res.entry_offset = cursor;
                res.entry_length = length_mem[slot];
                res.next_offset = step_next;
                returned = returned + size_mem[slot];
                cursor = step_next;
                hits++;
            end
            if (hits == 0)
            begin
                res = stamp_result(KIND_MISS);
            end
            res.last = 1'b1;
            results_due.insert(results_due.size(), res);
        end
    endtask

    // Request driver
    always @(posedge clk)
    begin
        int send_gap;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_cache_op(current_request);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (queued_requests.size() > 0)
                begin
                    current_request = queued_requests[0];
                    queued_requests.delete(0);
                    s_axis_tdata <= {current_request.read_limit, current_request.fragment_len,
                                     current_request.disk_size, current_request.offset};
                    s_axis_tuser <= current_request.op;
                    s_axis_tvalid <= 1'b1;
                    send_gap = ($urandom_range(99) < send_idle_pct) ? rand_gap() : 0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk)
    begin
        int            hold_left;
        int            stall_left;
        cache_result_t got;
        cache_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                got.entry_offset = m_axis_tdata[63:0];
                got.entry_length = m_axis_tdata[95:64];
                got.evicted = m_axis_tdata[101:96];
                got.next_offset = m_axis_tdata[165:102];
                got.oldest_offset = m_axis_tdata[229:166];
                got.newest_offset = m_axis_tdata[293:230];
                got.last = m_axis_tlast;
                if (results_due.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 64'(got.kind), '0);
                end
                else
                begin
                    want = results_due[0];
                    results_due.delete(0);
                    if (got.kind !== want.kind)
                        report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                    if (got.entry_offset !== want.entry_offset)
                        report_mismatch("entry_offset", got.entry_offset, want.entry_offset);
                    if (got.entry_length !== want.entry_length)
                        report_mismatch("entry_length", 64'(got.entry_length),
                                        64'(want.entry_length));
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted_count", 64'(got.evicted), 64'(want.evicted));
                    if (got.next_offset !== want.next_offset)
                        report_mismatch("next_offset", got.next_offset, want.next_offset);
                    if (got.oldest_offset !== want.oldest_offset)
                        report_mismatch("oldest_offset", got.oldest_offset,
                                        want.oldest_offset);
                    if (got.newest_offset !== want.newest_offset)
                        report_mismatch("newest_offset", got.newest_offset,
                                        want.newest_offset);
                    if (got.last !== want.last)
                        report_mismatch("last", 64'(got.last), 64'(want.last));
                end
                results_seen++;
            end
            // Long hold-off on request, otherwise short random stalls
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(99) < recv_stall_pct)
            begin
                stall_left = rand_gap() - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_field(input int unsigned cap);
        case ($urandom_range(19))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(0, cap);
        endcase
    endfunction

    function automatic logic [63:0] rand_key();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return 64'($urandom_range(0, 100000));
        else if (pick < 9)
            return {$urandom, $urandom};
        else
            return {32'hFFFF_FFFF, $urandom};
    endfunction

    task automatic push_put(input logic [63:0] key, input logic [31:0] size,
                            input logic [31:0] len);
        cache_request_t req;
        req.op = OP_PUT;
        req.offset = key;
        req.disk_size = size;
        req.fragment_len = len;
        req.read_limit = $urandom;
        queued_requests.insert(queued_requests.size(), req);
        recent_keys.insert(recent_keys.size(), key);
        if (recent_keys.size() > KEY_HISTORY)
        begin
            recent_keys.delete(0);
        end
        items_made++;
    endtask

    task automatic push_get(input logic [63:0] start, input logic [31:0] limit);
        cache_request_t req;
        req.op = OP_GET;
        req.offset = start;
        req.disk_size = $urandom;
        req.fragment_len = $urandom;
        req.read_limit = limit;
        queued_requests.insert(queued_requests.size(), req);
        items_made++;
    endtask

    // Runs of consecutive puts, most followed by a read into them, mixed with single puts and gets
    task automatic random_phase(input int n_items, input int unsigned size_cap,
                                input int unsigned len_cap, input int unsigned limit_cap);
        int          first_item;
        int          pick;
        int          run_len;
        int          k;
        logic [63:0] cursor;
        logic [31:0] len;
        first_item = items_made;
        while (items_made - first_item < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                run_len = $urandom_range(1, 6);
                cursor = rand_key();
                for (k = 0; k < run_len; k++)
                begin
                    len = rand_field(len_cap);
                    push_put(cursor, rand_field(size_cap), len);
                    cursor = cursor + len + header_reg;
                end
                if ($urandom_range(9) < 7)
                begin
                    push_get(recent_keys[recent_keys.size() - 1 - $urandom_range(0, run_len - 1)],
                             rand_field(limit_cap));
                end
            end
            else if (pick < 75 && recent_keys.size() > 0)
            begin
                push_get(recent_keys[$urandom_range(0, recent_keys.size() - 1)],
                         rand_field(limit_cap));
            end
            else if (pick < 87)
            begin
                if (recent_keys.size() > 0 && $urandom_range(1) == 1)
                    cursor = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    cursor = rand_key();
                push_put(cursor, rand_field(size_cap), rand_field(len_cap));
            end
            else
            begin
                push_get(rand_key(), rand_field(limit_cap));
            end
        end
    endtask

    task automatic write_register(input logic index, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_BUDGET)
            budget_reg = value;
        else
            header_reg = value[11:0];
    endtask

    // Wait until every queued request is taken and every result has come
    task automatic drain_results();
        do
            @(posedge clk);
        while (queued_requests.size() != 0 || s_axis_tvalid || results_due.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty cache, zero advance, wrap, oversized entry, runs
        push_get(64'd0, 32'hFFFF_FFFF);
        push_put(64'd0, 32'd0, 32'd0);
        push_get(64'd0, 32'hFFFF_FFFF);
        push_get(64'd0, 32'd0);
        push_put(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_get(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        push_put(64'h0000_0000_FFFF_FFFE, 32'd1, 32'd5);
        push_get(64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        push_put(64'd1000, 32'd100, 32'd10);
        push_put(64'd1010, 32'd200, 32'd20);
        push_put(64'd1030, 32'd300, 32'd30);
        push_put(64'd1060, 32'd400, 32'd40);
        push_put(64'd1010, 32'd50, 32'd7);
        push_put(64'd500, 32'd10, 32'd500);
        push_get(64'd500, 32'hFFFF_FFFF);
        push_get(64'd1000, 32'd250);
        push_get(64'd1010, 32'd1);
        push_get(64'd1005, 32'hFFFF_FFFF);
        push_get(64'h0000_0000_FFFF_FFFE, 32'd0);
        random_phase(60, 4000, 200, 3000);
        drain_results();

        // Widest settings; the receiver holds off while requests pile up
        write_register(CFG_BUDGET, 32'hFFFF_FFFF);
        write_register(CFG_HEADER, 32'd4095);
        send_idle_pct = 0;
        hold_requests++;
        random_phase(90, 100000, 5000, 400000);
        drain_results();

        // Zero budget: every put of nonzero size displaces what is held
        write_register(CFG_BUDGET, 32'd0);
        write_register(CFG_HEADER, 32'd0);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_phase(60, 1000, 100, 2000);
        drain_results();

        // Tight budget so that byte eviction dominates
        write_register(CFG_BUDGET, 32'd6000);
        write_register(CFG_HEADER, $urandom_range(1, 64));
        random_phase(90, 1500, 300, 4000);
        drain_results();

        // Stretch with no idling on either side
        write_register(CFG_BUDGET, BUDGET_RESET);
        write_register(CFG_HEADER, 32'd0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(80, 200000, 1000, 1000000);
        drain_results();

        // Random settings
        write_register(CFG_BUDGET, $urandom);
        write_register(CFG_HEADER, $urandom_range(0, 4095));
        send_idle_pct = 40;
        recv_stall_pct = 40;
        random_phase(70, 50000, 2000, 200000);
        drain_results();

        repeat (50) @(posedge clk);
        if (results_due.size() != 0)
        begin
            report_mismatch("results never delivered", '0, 64'(results_due.size()));
        end
        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sbfoc_pkg.sv
rtl/sbfoc_ram.sv
rtl/size_budget_fifo_offset_cache.sv
tb/tb.sv
